### hdl/crm_pkg.sv
package crm_pkg;

  localparam int POS_FIELD_BITS = 32;
  localparam int COUNT_BITS     = 16;
  localparam int WEIGHT_BITS    = 32;
  localparam int TAG_BITS       = 16;
  localparam int VALUE_BITS     = 48;
  localparam int NUM_TRACKS     = 3;

  localparam logic OP_COVER = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    TRK_ALL    = 2'd0,
    TRK_UNIQUE = 2'd1,
    TRK_SHARED = 2'd2
  } track_t;

  // back end walks the tracks in result order
  typedef enum logic [1:0] {
    STEP_UNIQUE,
    STEP_SHARED,
    STEP_ALL
  } step_t;

  typedef struct packed {
    logic                        opcode;
    logic [POS_FIELD_BITS-1:0]   position;
    logic [COUNT_BITS-1:0]       unique_count;
    logic [WEIGHT_BITS-1:0]      shared_weight;
    logic [TAG_BITS-1:0]         sequence_index;
  } item_t;

  typedef struct packed {
    track_t                      track;
    logic [TAG_BITS-1:0]         sequence_tag;
    logic [POS_FIELD_BITS-1:0]   run_start;
    logic [POS_FIELD_BITS-1:0]   run_end;
    logic signed [VALUE_BITS-1:0] run_value;
    logic                        last_of_run;
  } result_t;

  // classified request between front and back
  typedef struct packed {
    logic                         flush;
    logic                         use_unique;
    logic                         use_shared;
    logic [POS_FIELD_BITS-1:0]    loc;
    logic [TAG_BITS-1:0]          tag;
    logic signed [VALUE_BITS-1:0] up_val;
    logic signed [VALUE_BITS-1:0] down_val;
    logic signed [VALUE_BITS-1:0] all_val;
  } cmd_t;

endpackage

### hdl/crm_fifo.sv
module crm_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  import crm_pkg::*;

  logic [WIDTH-1:0] head;
  logic [WIDTH-1:0] spare;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign dout    = head;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  // two entries: head is the oldest, spare the one behind it
  always_ff @(posedge clk) begin
    if (do_pop) begin
      if (do_push && (count == 2'd1)) begin
        head <= din;
      end else begin
        head <= spare;
      end
      if (do_push && (count == 2'd2)) begin
        spare <= din;
      end
    end else if (do_push) begin
      if (count == 2'd0) begin
        head <= din;
      end else begin
        spare <= din;
      end
    end
  end

endmodule

### hdl/crm_front.sv
module crm_front #(
  parameter int PW            = 32,
  parameter int FRACTION_BITS = 16
) (
  input  crm_pkg::item_t item,
  output crm_pkg::cmd_t  cmd
);
  import crm_pkg::*;

  localparam logic [POS_FIELD_BITS-1:0] PosMask = POS_FIELD_BITS'((64'd1 << PW) - 64'd1);

  logic [VALUE_BITS-1:0] up;
  logic [VALUE_BITS-1:0] weight;

  assign up     = VALUE_BITS'(item.unique_count) << FRACTION_BITS;
  assign weight = VALUE_BITS'(item.shared_weight);

  always_comb begin
    cmd.flush      = (item.opcode == OP_FLUSH);
    cmd.use_unique = (item.unique_count != '0);
    cmd.use_shared = (item.shared_weight != '0);
    cmd.loc        = item.position & PosMask;
    cmd.tag        = item.sequence_index;
    cmd.up_val     = up;
    cmd.down_val   = '0 - weight;
    cmd.all_val    = up + weight;
  end

endmodule

### hdl/crm_back.sv
module crm_back #(
  parameter int PW = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_empty,
  input  crm_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output crm_pkg::result_t res
);
  import crm_pkg::*;

  step_t  step;
  step_t  step_next;
  track_t cur_trk;
  logic   later_emit;
  logic   last_step;

  logic [PW-1:0]                open_start [NUM_TRACKS];
  logic [PW-1:0]                open_end   [NUM_TRACKS];
  logic signed [VALUE_BITS-1:0] open_value [NUM_TRACKS];

  logic [PW-1:0]                start_next [NUM_TRACKS];
  logic [PW-1:0]                end_next   [NUM_TRACKS];
  logic signed [VALUE_BITS-1:0] value_next [NUM_TRACKS];
  logic signed [VALUE_BITS-1:0] vals       [NUM_TRACKS];

  logic [NUM_TRACKS-1:0] present;
  logic [NUM_TRACKS-1:0] is_open;
  logic [NUM_TRACKS-1:0] same;
  logic [NUM_TRACKS-1:0] adjacent;
  logic [NUM_TRACKS-1:0] emit;
  logic [PW-1:0]         loc;
  logic [1:0]            cur_idx;
  logic                  emit_cur;
  logic                  advance;

  assign loc = cmd.loc[PW-1:0];

  // per-track decision, all three evaluated side by side
  always_comb begin
    vals[TRK_ALL]       = cmd.all_val;
    vals[TRK_UNIQUE]    = cmd.up_val;
    vals[TRK_SHARED]    = cmd.down_val;
    present[TRK_ALL]    = 1'b1;
    present[TRK_UNIQUE] = cmd.use_unique;
    present[TRK_SHARED] = cmd.use_shared;
    for (int t = 0; t < NUM_TRACKS; t++) begin
      is_open[t]  = (open_start[t] != '0);
      same[t]     = (vals[t] == open_value[t]);
      // no wrap: the top position is never adjacent to zero
      adjacent[t] = (({1'b0, open_end[t]} + (PW+1)'(1)) == {1'b0, loc});
      if (cmd.flush) begin
        emit[t]       = is_open[t];
        start_next[t] = '0;
        end_next[t]   = '0;
        value_next[t] = '0;
      end else if (!present[t]) begin
        emit[t]       = 1'b0;
        start_next[t] = open_start[t];
        end_next[t]   = open_end[t];
        value_next[t] = open_value[t];
      end else if (same[t] && is_open[t] && adjacent[t]) begin
        emit[t]       = 1'b0;
        start_next[t] = open_start[t];
        end_next[t]   = loc;
        value_next[t] = open_value[t];
      end else begin
        emit[t]       = is_open[t];
        start_next[t] = loc;
        end_next[t]   = loc;
        value_next[t] = vals[t];
      end
    end
  end

  // step sequencer: next state
  always_comb begin
    step_next = step;
    if (advance) begin
      case (step)
        STEP_UNIQUE: step_next = STEP_SHARED;
        STEP_SHARED: step_next = STEP_ALL;
        STEP_ALL:    step_next = STEP_UNIQUE;
        default:     step_next = STEP_UNIQUE;
      endcase
    end
  end

  // step sequencer: outputs
  always_comb begin
    case (step)
      STEP_UNIQUE: begin
        cur_trk    = TRK_UNIQUE;
        later_emit = emit[TRK_SHARED] || emit[TRK_ALL];
        last_step  = 1'b0;
      end
      STEP_SHARED: begin
        cur_trk    = TRK_SHARED;
        later_emit = emit[TRK_ALL];
        last_step  = 1'b0;
      end
      STEP_ALL: begin
        cur_trk    = TRK_ALL;
        later_emit = 1'b0;
        last_step  = 1'b1;
      end
      default: begin
        cur_trk    = TRK_UNIQUE;
        later_emit = 1'b0;
        last_step  = 1'b0;
      end
    endcase
  end

  assign cur_idx  = cur_trk;
  assign emit_cur = emit[cur_idx];
  assign advance  = !cmd_empty && !(emit_cur && res_full);
  assign cmd_pop  = advance && last_step;
  assign res_push = advance && emit_cur;

  always_comb begin
    res.track        = cur_trk;
    res.sequence_tag = cmd.tag;
    res.run_start    = POS_FIELD_BITS'(open_start[cur_idx]);
    res.run_end      = POS_FIELD_BITS'(open_end[cur_idx]);
    res.run_value    = open_value[cur_idx];
    res.last_of_run  = !later_emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_UNIQUE;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NUM_TRACKS; t++) begin
        open_start[t] <= '0;
        open_end[t]   <= '0;
        open_value[t] <= '0;
      end
    end else if (advance) begin
      open_start[cur_idx] <= start_next[cur_idx];
      open_end[cur_idx]   <= end_next[cur_idx];
      open_value[cur_idx] <= value_next[cur_idx];
    end
  end

endmodule

### hdl/coverage_run_merger.sv
// with both queues idle and results taken at once, a request shows its unique interval
//   first, its non-unique interval next and its all interval last
// the back-end sequencer steps the three tracks in turn against the single result port, so
//   a request leaves the request queue only once all three of its tracks are done
// a 2-entry request queue and a 2-entry result queue decouple both sides
// reset: synchronous, active high; empties both queues and closes every open interval
module coverage_run_merger #(
  parameter int POSITION_BITS = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  crm_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output crm_pkg::result_t result
);
  import crm_pkg::*;

  // positions never exceed the 32-bit field, so state is at most that wide
  localparam int PW        = (POSITION_BITS < POS_FIELD_BITS) ? POSITION_BITS : POS_FIELD_BITS;
  localparam int CmdBits   = $bits(cmd_t);
  localparam int ResBits   = $bits(result_t);

  cmd_t               front_cmd;
  cmd_t               back_cmd;
  logic [CmdBits-1:0] cmd_vec;
  logic               cmd_empty;
  logic               cmd_pop;

  result_t            back_res;
  logic [ResBits-1:0] res_vec;
  logic               res_push;
  logic               res_full;

  // front: masks the position and builds the three track values
  crm_front #(
    .PW            (PW),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .item (item),
    .cmd  (front_cmd)
  );

  // request queue: front keeps accepting while the back end works
  crm_fifo #(
    .WIDTH (CmdBits)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_cmd),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_vec),
    .empty (cmd_empty)
  );

  assign back_cmd = cmd_t'(cmd_vec);

  // back: per-track run state, one track per cycle in result order unless stalled
  crm_back #(
    .PW (PW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  // result queue: a waiting interval stalls the back end only once this queue is full
  crm_fifo #(
    .WIDTH (ResBits)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_vec),
    .empty (empty)
  );

  assign result = result_t'(res_vec);

endmodule

### hdl/crm_checker.sv
module crm_checker (
  input logic             clk,
  input logic             rst,
  input logic             push,
  input logic             full,
  input crm_pkg::item_t   item,
  input logic             empty,
  input logic             pop,
  input crm_pkg::result_t result
);
  import crm_pkg::*;

  // reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // a waiting interval holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting interval changed before pop");

  // no interval ever starts at position zero
  a_start_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.run_start != '0))
    else $error("interval starts at zero");

  // runs only grow forward
  a_end_after_start: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.run_end >= result.run_start))
    else $error("interval ends before it starts");

endmodule

bind coverage_run_merger crm_checker u_crm_checker (.*);
